@@ hdl/assert_macros.svh @@
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Check that a condition never holds on a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ hdl/pps_pkg.sv @@
// Types and constants shared by the scheduler cells and the top level.
`default_nettype none
package pps_pkg;

    localparam int unsigned ID_W    = 8;
    localparam int unsigned TIME_W  = 16;
    localparam int unsigned BURST_W = 16;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned TICK_W  = 24;

    // Action codes of an input item
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Fields written into a table entry by a load
    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_load;

    // Best candidate handed down the cell chain during a scan
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   ident;
        logic              last;   // remaining burst is at most one
    } t_cand;

endpackage
`default_nettype wire

@@ hdl/pps_cell.sv @@
// One table entry of the scheduler with its compare stage in the scan chain.
`default_nettype none
module pps_cell #(
    parameter int unsigned IW  = 4,
    parameter int unsigned IDX = 0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_wr,
    input  wire pps_pkg::t_load            i_load,
    input  wire [pps_pkg::TICK_W-1:0]      i_now,
    input  wire                            i_dec,
    input  wire                            i_tok,
    input  wire pps_pkg::t_cand            i_cand,
    input  wire [IW-1:0]                   i_idx,
    output logic                           o_tok,
    output pps_pkg::t_cand                 o_cand,
    output logic [IW-1:0]                  o_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                         r_live;
    logic [pps_pkg::ID_W-1:0]     r_ident;
    logic [pps_pkg::TIME_W-1:0]   r_arrival;
    logic [pps_pkg::BURST_W-1:0]  r_rem;
    logic [pps_pkg::PRIO_W-1:0]   r_prio;

    logic eligible;
    logic take;
    logic rem_last;

    // Compare own entry against the incoming candidate
    assign eligible = r_live &&
        ({{(pps_pkg::TICK_W-pps_pkg::TIME_W){1'b0}}, r_arrival} <= i_now);
    assign take     = eligible && (!i_cand.found || (r_prio > i_cand.prio));
    assign rem_last = (r_rem <= pps_pkg::BURST_W'(1));

    // Hold the entry: load, then serve one unit at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_wr) begin
            r_live <= 1'b1;
        end else if (i_dec && rem_last) begin
            r_live <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ident   <= i_load.ident;
            r_arrival <= i_load.arrival;
            r_rem     <= i_load.burst;
            r_prio    <= i_load.prio;
        end else if (i_dec) begin
            r_rem <= rem_last ? '0 : r_rem - pps_pkg::BURST_W'(1);
        end
    end

    // Advance the scan token one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok <= 1'b0;
        end else begin
            o_tok <= i_tok;
        end
    end

    // Pass on the better of own entry and the incoming candidate
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            if (take) begin
                o_cand.found <= 1'b1;
                o_cand.prio  <= r_prio;
                o_cand.ident <= r_ident;
                o_cand.last  <= rem_last;
                o_idx        <= MY_IDX;
            end else begin
                o_cand <= i_cand;
                o_idx  <= i_idx;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/preemptive_priority_scheduler.sv @@
// Top level of the preemptive priority scheduler: cell chain and tick control.
// Usage:
//   An item is taken when start is high and busy is low. Action load writes
//   the next table entry (id, arrival, burst, priority) in the accepting cycle
//   and leaves busy low, so loads go back to back. Loads past MAX_JOBS entries
//   are dropped; retired slots are not reused.
//   Action tick sends a scan token down the row of MAX_JOBS cells, one cell
//   per cycle; each cell keeps the better of its own entry and the candidate
//   handed to it. When the token leaves the last cell the chosen entry is
//   charged one unit, the time advances and busy drops. The result is
//   registered as the token leaves the last cell and shows on the o_ ports
//   for one cycle with o_valid high; a tick thus takes as long as the
//   token needs to pass the cell chain. A new item can be taken in the
//   cycle the result is shown. Loads produce no result.
//   The receiver cannot stall: o_valid lasts one cycle and is not held.
//   Reset (synchronous, active low) empties the table, zeroes the time and
//   the load count and forgets the last served job.
`default_nettype none
`include "assert_macros.svh"
module preemptive_priority_scheduler #(
    parameter int unsigned MAX_JOBS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_action,
    input  wire [pps_pkg::ID_W-1:0]          i_job_id,
    input  wire [pps_pkg::TIME_W-1:0]        i_arrival,
    input  wire [pps_pkg::BURST_W-1:0]       i_burst,
    input  wire [pps_pkg::PRIO_W-1:0]        i_prio,
    output logic                             o_valid,
    output logic                             o_busy_res,
    output logic [pps_pkg::ID_W-1:0]         o_run_id,
    output logic                             o_switched,
    output logic                             o_finished,
    output logic [pps_pkg::TICK_W-1:0]       o_finish_time,
    output logic                             o_all_done
);

    localparam int unsigned IW = $clog2(MAX_JOBS);
    localparam int unsigned CW = $clog2(MAX_JOBS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_JOBS);

    logic                          r_busy;
    logic [CW-1:0]                 r_load_cnt;
    logic [CW-1:0]                 r_live_cnt;
    logic [pps_pkg::TICK_W-1:0]    r_now;
    logic [pps_pkg::ID_W-1:0]      r_last_id;
    logic                          r_last_vld;

    logic                          accept;
    logic                          load_acc;
    logic                          tick_acc;
    logic                          full;
    logic                          scan_done;
    logic                          served;
    logic                          fin;
    logic [CW-1:0]                 n_live_cnt;
    pps_pkg::t_load                load_bus;

    logic                          tok  [0:MAX_JOBS];
    pps_pkg::t_cand                cand [0:MAX_JOBS];
    logic [IW-1:0]                 idx  [0:MAX_JOBS];

    assign busy     = r_busy;
    assign accept   = start && !r_busy;
    assign load_acc = accept && (i_action == pps_pkg::ACT_LOAD);
    assign tick_acc = accept && (i_action == pps_pkg::ACT_TICK);
    assign full     = (r_load_cnt >= FULL_CNT);

    assign load_bus.ident   = i_job_id;
    assign load_bus.arrival = i_arrival;
    assign load_bus.burst   = i_burst;
    assign load_bus.prio    = i_prio;

    // Inject the scan token with an empty candidate
    assign tok[0]  = tick_acc;
    assign cand[0] = '0;
    assign idx[0]  = '0;

    // Row of table cells
    for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
        logic wr;
        logic dec;
        assign wr  = load_acc && !full && (r_load_cnt[IW-1:0] == IW'(k));
        assign dec = served && (idx[MAX_JOBS] == IW'(k));
        pps_cell #(
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_load  (load_bus),
            .i_now   (r_now),
            .i_dec   (dec),
            .i_tok   (tok[k]),
            .i_cand  (cand[k]),
            .i_idx   (idx[k]),
            .o_tok   (tok[k+1]),
            .o_cand  (cand[k+1]),
            .o_idx   (idx[k+1])
        );
    end

    // Close out the tick when the token leaves the last cell
    assign scan_done  = tok[MAX_JOBS];
    assign served     = scan_done && cand[MAX_JOBS].found;
    assign fin        = served && cand[MAX_JOBS].last;
    assign n_live_cnt = fin ? r_live_cnt - CW'(1) : r_live_cnt;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_load_cnt <= '0;
            r_live_cnt <= '0;
            r_now      <= '0;
            r_last_id  <= '0;
            r_last_vld <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= scan_done;
            if (tick_acc) begin
                r_busy <= 1'b1;
            end else if (scan_done) begin
                r_busy <= 1'b0;
            end
            if (load_acc && !full) begin
                r_load_cnt <= r_load_cnt + CW'(1);
                r_live_cnt <= r_live_cnt + CW'(1);
            end else if (scan_done) begin
                r_live_cnt <= n_live_cnt;
            end
            if (scan_done) begin
                r_now <= r_now + pps_pkg::TICK_W'(1);
            end
            if (served) begin
                r_last_id  <= cand[MAX_JOBS].ident;
                r_last_vld <= 1'b1;
            end
        end
    end

    // Register the result fields
    always_ff @(posedge i_clk) begin
        if (scan_done) begin
            o_busy_res    <= served;
            o_run_id      <= served ? cand[MAX_JOBS].ident : '0;
            o_switched    <= served &&
                             (!r_last_vld || (r_last_id != cand[MAX_JOBS].ident));
            o_finished    <= fin;
            o_finish_time <= fin ? r_now : '0;
            o_all_done    <= (n_live_cnt == '0);
        end
    end

    `ASSERT_CLK(a_scan_ends, i_clk, i_rst_n, scan_done |-> r_busy)
    `ASSERT_CLK(a_result_after_scan, i_clk, i_rst_n, scan_done |=> (o_valid && !r_busy))
    `ASSERT_NEVER(a_live_le_load, i_clk, i_rst_n, r_live_cnt > r_load_cnt)
    `ASSERT_CLK(a_fin_is_busy, i_clk, i_rst_n, (o_valid && o_finished) |-> o_busy_res)

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the preemptive priority scheduler.
`timescale 1ns / 1ps
module testbench;

    localparam int JOBS        = 16;
    localparam int RAND_ITEMS  = 1630;
    localparam int PHASE_LEN   = 160;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = JOBS + 4;

    typedef struct packed {
        logic                        action;
        logic [pps_pkg::ID_W-1:0]    job_id;
        logic [pps_pkg::TIME_W-1:0]  arrival;
        logic [pps_pkg::BURST_W-1:0] burst;
        logic [pps_pkg::PRIO_W-1:0]  prio;
    } t_sched_item;

    typedef struct packed {
        logic                       busy_res;
        logic [pps_pkg::ID_W-1:0]   run_id;
        logic                       switched;
        logic                       finished;
        logic [pps_pkg::TICK_W-1:0] finish_time;
        logic                       all_done;
    } t_sched_result;

    // One line of the directed stimulus; known holds a hand-written result
    typedef struct packed {
        logic          typed;
        t_sched_item   item;
        t_sched_result known;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        i_action = pps_pkg::ACT_LOAD;
    logic [pps_pkg::ID_W-1:0]    i_job_id = '0;
    logic [pps_pkg::TIME_W-1:0]  i_arrival = '0;
    logic [pps_pkg::BURST_W-1:0] i_burst = '0;
    logic [pps_pkg::PRIO_W-1:0]  i_prio = '0;
    logic                        busy;
    logic                        o_valid;
    logic                        o_busy_res;
    logic [pps_pkg::ID_W-1:0]    o_run_id;
    logic                        o_switched;
    logic                        o_finished;
    logic [pps_pkg::TICK_W-1:0]  o_finish_time;
    logic                        o_all_done;

    preemptive_priority_scheduler #(.MAX_JOBS(JOBS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_job_id      (i_job_id),
        .i_arrival     (i_arrival),
        .i_burst       (i_burst),
        .i_prio        (i_prio),
        .o_valid       (o_valid),
        .o_busy_res    (o_busy_res),
        .o_run_id      (o_run_id),
        .o_switched    (o_switched),
        .o_finished    (o_finished),
        .o_finish_time (o_finish_time),
        .o_all_done    (o_all_done)
    );

    always #4 i_clk = ~i_clk;

    // Job table as the scheduler should hold it
    logic                        slot_live [JOBS];
    logic [pps_pkg::ID_W-1:0]    slot_id   [JOBS];
    logic [pps_pkg::TIME_W-1:0]  slot_arr  [JOBS];
    logic [pps_pkg::BURST_W-1:0] slot_left [JOBS];
    logic [pps_pkg::PRIO_W-1:0]  slot_prio [JOBS];
    int                          slots_used = 0;
    logic [pps_pkg::TICK_W-1:0]  tick_now = '0;
    logic [pps_pkg::ID_W-1:0]    prev_id = '0;
    logic                        prev_valid = 1'b0;

    t_sched_result      due_results [$];
    int                 mismatches = 0;
    int                 stall_cycles = 0;

    // Apply one item to the table; return 1 when it yields a result
    function automatic bit apply_item(input t_sched_item it, output t_sched_result res);
        int pick;
        bit found;
        bit any_left;
        pick = 0;
        found = 1'b0;
        any_left = 1'b0;
        res = '0;
        if (it.action == pps_pkg::ACT_LOAD) begin
            if (slots_used < JOBS) begin
                slot_id[slots_used]   = it.job_id;
                slot_arr[slots_used]  = it.arrival;
                slot_left[slots_used] = it.burst;
                slot_prio[slots_used] = it.prio;
                slot_live[slots_used] = 1'b1;
                slots_used++;
            end
            return 1'b0;
        end
        // Pick the arrived job of highest priority, earliest slot on a tie
        for (int i = 0; i < JOBS; i++) begin
            if (slot_live[i] && pps_pkg::TICK_W'(slot_arr[i]) <= tick_now &&
                    (!found || slot_prio[i] > slot_prio[pick])) begin
                pick = i;
                found = 1'b1;
            end
        end
        if (found) begin
            res.busy_res = 1'b1;
            res.run_id = slot_id[pick];
            res.switched = !prev_valid || prev_id != slot_id[pick];
            prev_id = slot_id[pick];
            prev_valid = 1'b1;
            if (slot_left[pick] <= pps_pkg::BURST_W'(1)) begin
                slot_left[pick] = '0;
                slot_live[pick] = 1'b0;
                res.finished = 1'b1;
                res.finish_time = tick_now;
            end else begin
                slot_left[pick] = slot_left[pick] - pps_pkg::BURST_W'(1);
            end
        end
        for (int i = 0; i < JOBS; i++) begin
            if (slot_live[i]) begin
                any_left = 1'b1;
            end
        end
        res.all_done = !any_left;
        tick_now = tick_now + pps_pkg::TICK_W'(1);
        return 1'b1;
    endfunction

    function automatic t_dir_row load_row(input logic [pps_pkg::ID_W-1:0] id,
                                          input logic [pps_pkg::TIME_W-1:0] arr,
                                          input logic [pps_pkg::BURST_W-1:0] len,
                                          input logic [pps_pkg::PRIO_W-1:0] pr);
        t_dir_row r;
        r = '0;
        r.item.action = pps_pkg::ACT_LOAD;
        r.item.job_id = id;
        r.item.arrival = arr;
        r.item.burst = len;
        r.item.prio = pr;
        return r;
    endfunction

    function automatic t_dir_row tick_row(input logic typed, input t_sched_result known);
        t_dir_row r;
        r = '0;
        r.typed = typed;
        r.item.action = pps_pkg::ACT_TICK;
        r.known = known;
        return r;
    endfunction

    // Draw a random item: mostly ticks, loads near the current time
    function automatic t_sched_item draw_item();
        t_sched_item it;
        it.action = pps_pkg::ACT_TICK;
        it.job_id = pps_pkg::ID_W'($urandom);
        it.arrival = pps_pkg::TIME_W'($urandom);
        it.burst = pps_pkg::BURST_W'($urandom);
        it.prio = pps_pkg::PRIO_W'($urandom);
        if ($urandom_range(0, 99) < 5) begin
            it.action = pps_pkg::ACT_LOAD;
            if ($urandom_range(0, 3) == 0) begin
                it.job_id = pps_pkg::ID_W'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) != 0) begin
                it.arrival = tick_now[pps_pkg::TIME_W-1:0] +
                             pps_pkg::TIME_W'($urandom_range(0, 24));
            end
            case ($urandom_range(0, 19))
                0: begin
                    it.burst = '0;
                end
                1: begin
                    // keep the full-range burst
                end
                default: begin
                    it.burst = pps_pkg::BURST_W'($urandom_range(1, 10));
                end
            endcase
            if ($urandom_range(0, 9) < 7) begin
                it.prio = pps_pkg::PRIO_W'($urandom_range(0, 3));
            end
        end
        return it;
    endfunction

    // Hold start low for a random gap, then present the item until taken
    task automatic send_item(input t_sched_item it, input logic typed,
                             input t_sched_result known, input int idle_pct);
        t_sched_result predicted;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= it.action;
        i_job_id <= it.job_id;
        i_arrival <= it.arrival;
        i_burst <= it.burst;
        i_prio <= it.prio;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (apply_item(it, predicted)) begin
            due_results = {due_results, (typed ? known : predicted)};
        end
    endtask

    // Drop start and wait until every expected result is back
    task automatic wait_results_out();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (due_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: run_id %0h", o_run_id);
                end
            end else begin
                want = due_results.pop_front();
                check_field("busy_res", 32'(want.busy_res), 32'(o_busy_res));
                check_field("run_id", 32'(want.run_id), 32'(o_run_id));
                check_field("switched", 32'(want.switched), 32'(o_switched));
                check_field("finished", 32'(want.finished), 32'(o_finished));
                check_field("finish_time", 32'(want.finish_time), 32'(o_finish_time));
                check_field("all_done", 32'(want.all_done), 32'(o_all_done));
            end
        end
    end

    // Abort when neither items nor results move for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row      dir_rows [$];
        int            idle_by_phase [4];
        t_sched_item   it;
        int            rand_done;
        int            phase;
        bit            counts;
        idle_by_phase = '{0, 72, 0, 20};
        rand_done = 0;
        phase = 0;
        for (int i = 0; i < JOBS; i++) begin
            slot_live[i] = 1'b0;
        end

        // Empty table, zero burst at top priority, then same-id and tie cases
        dir_rows = {dir_rows, tick_row(1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 24'd0, 1'b1})};
        dir_rows = {dir_rows, load_row(8'hFF, 16'h0000, 16'h0000, 8'hFF)};
        dir_rows = {dir_rows, tick_row(1'b1, {1'b1, 8'hFF, 1'b1, 1'b1, 24'd1, 1'b1})};
        dir_rows = {dir_rows, tick_row(1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 24'd0, 1'b1})};
        dir_rows = {dir_rows, load_row(8'hFF, 16'h0000, 16'h0002, 8'h00)};
        dir_rows = {dir_rows, tick_row(1'b0, '0)};
        dir_rows = {dir_rows, load_row(8'h01, 16'h0000, 16'h0001, 8'h00)};
        dir_rows = {dir_rows, tick_row(1'b0, '0)};
        dir_rows = {dir_rows, tick_row(1'b0, '0)};
        // Job that never arrives, then preemption by a later arrival
        dir_rows = {dir_rows, load_row(8'h00, 16'hFFFF, 16'hFFFF, 8'h00)};
        dir_rows = {dir_rows, load_row(8'hAA, 16'h0000, 16'h0005, 8'h40)};
        dir_rows = {dir_rows, load_row(8'h55, 16'h0008, 16'h0003, 8'h80)};
        for (int i = 0; i < 8; i++) begin
            dir_rows = {dir_rows, tick_row(1'b0, '0)};
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].known, 0);
        end
        wait_results_out();

        // Random items in phases of sender idling, draining at each change
        while (rand_done < RAND_ITEMS) begin
            if ((rand_done / PHASE_LEN) % 4 != phase) begin
                phase = (rand_done / PHASE_LEN) % 4;
                wait_results_out();
            end
            it = draw_item();
            counts = (it.action == pps_pkg::ACT_TICK) || (slots_used < JOBS);
            send_item(it, 1'b0, '0, idle_by_phase[phase]);
            if (counts) begin
                rand_done++;
            end
        end

        wait_results_out();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/preemptive_priority_scheduler.sv
tb/testbench.sv
